@@ rtl/flrs_pkg.sv @@
// Package with the types, codes and constants of the firmware load retry sequencer.
`timescale 1ns / 1ps
package flrs_pkg;

	// Sequencer phases.
	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_START_DELAY  = 3'd1,
		PH_WAIT_ACK     = 3'd2,
		PH_WAIT_ENTERED = 3'd3,
		PH_WAIT_REPLY   = 3'd4,
		PH_EXIT_DELAY   = 3'd5,
		PH_WAIT_EXITED  = 3'd6
	} phase_t;

	// Actions carried in each result.
	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_APP    = 3'd1,
		ACT_ENTER  = 3'd2,
		ACT_INSTR  = 3'd3,
		ACT_EXIT   = 3'd4,
		ACT_STATUS = 3'd5
	} action_t;

	// Input operations.
	localparam logic [1:0] OP_START    = 2'd0;
	localparam logic [1:0] OP_TICK     = 2'd1;
	localparam logic [1:0] OP_RESPONSE = 2'd2;

	// Classified response codes.
	localparam logic [3:0] RSP_OK          = 4'd0;
	localparam logic [3:0] RSP_MANUAL      = 4'd1;
	localparam logic [3:0] RSP_BAD_SUM     = 4'd5;
	localparam logic [3:0] RSP_BAD_PARAM   = 4'd4;
	localparam logic [3:0] RSP_NOT_IN_MODE = 4'd6;
	localparam logic [3:0] RSP_ENTERED     = 4'd7;
	localparam logic [3:0] RSP_EXITED      = 4'd8;
	localparam logic [3:0] RSP_DATA        = 4'd9;
	localparam logic [3:0] RSP_READY       = 4'd10;

	// Final status codes.
	localparam logic [3:0] ST_SUCCESS       = 4'd0;
	localparam logic [3:0] ST_ENTER_TIMEOUT = 4'd6;
	localparam logic [3:0] ST_NOT_IN_MODE   = 4'd7;
	localparam logic [3:0] ST_INSTR_SPENT   = 4'd8;
	localparam logic [3:0] ST_EXIT_TIMEOUT  = 4'd9;
	localparam logic [3:0] ST_BUSY          = 4'd10;

	// Configuration register indexes.
	localparam logic [2:0] REG_MAX_ATTEMPTS  = 3'd0;
	localparam logic [2:0] REG_ACK_TIMEOUT   = 3'd1;
	localparam logic [2:0] REG_CONF_TIMEOUT  = 3'd2;
	localparam logic [2:0] REG_START_DELAY   = 3'd3;
	localparam logic [2:0] REG_EXIT_DELAY    = 3'd4;

	// Configuration reset values.
	localparam logic [2:0] RST_MAX_ATTEMPTS = 3'd3;
	localparam logic [9:0] RST_ACK_TIMEOUT  = 10'd50;
	localparam logic [9:0] RST_CONF_TIMEOUT = 10'd70;
	localparam logic [9:0] RST_START_DELAY  = 10'd5;
	localparam logic [9:0] RST_EXIT_DELAY   = 10'd20;

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// One result item.
	typedef struct packed {
		action_t    action;
		logic [9:0] index;
		logic [3:0] status;
		logic       last;
	} res_t;

	// Builds a result that is not yet marked as the last one.
	function automatic res_t mk_res(input action_t act, input logic [9:0] idx,
			input logic [3:0] st);
		res_t r;
		r.action = act;
		r.index  = idx;
		r.status = st;
		r.last   = 1'b0;
		return r;
	endfunction

endpackage

@@ rtl/firmware_load_retry_sequencer.sv @@
// Top level of the firmware load retry sequencer: input register, step logic and result queue.
`timescale 1ns / 1ps
// The sequencer takes one event transaction (start, tick or classified response) per clock
// while in_stall is low and turns it into zero, one or two result transactions, which leave
// one per cycle while out_stall is low. Events pass through an input register; when the held
// event advances, the step logic updates the phase, attempt, timer and index registers and
// pushes its results into a four-entry result queue, whose head drives the output. The input
// stalls while the held event cannot be pushed because the queue has fewer than two free
// entries, so sustained rate is one event per cycle as long as the results are taken at
// one per cycle; events that cause two results need two output transactions.
module firmware_load_retry_sequencer
	import flrs_pkg::*;
#(
	parameter int MAX_INSTRUCTIONS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [10:0] instruction_count,
	input  logic [3:0]  response_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [9:0]  instruction_index,
	output logic [3:0]  status,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	localparam int CNT_W = $clog2(MAX_INSTRUCTIONS + 1);
	localparam logic [31:0] MAX_CNT = 32'(MAX_INSTRUCTIONS);

	// Configuration registers.
	logic [2:0] max_attempts_q;
	logic [9:0] ack_timeout_q;
	logic [9:0] conf_timeout_q;
	logic [9:0] start_delay_q;
	logic [9:0] exit_delay_q;

	// Sequencer state.
	phase_t             phase_q, phase_n;
	logic [2:0]         attempt_q, attempt_n;
	logic [9:0]         timer_q, timer_n;
	logic [CNT_W-1:0]   cur_q, cur_n;
	logic [CNT_W-1:0]   total_q, total_n;

	// Input register.
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [10:0] cnt_s1;
	logic [3:0]  code_s1;

	// Result queue.
	res_t              queue_q [QDEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QCNT_W-1:0] qcnt_q;

	logic        advance;
	logic        pop;
	logic [1:0]  nres;
	res_t        res0, res1;
	logic        expire;
	logic        retry_ok;
	logic [2:0]  att_inc;
	logic [9:0]  timer_dec;
	logic [CNT_W-1:0] nx_idx;
	logic [CNT_W+9:0] cur_wide, nx_wide;
	logic [9:0]  cur_idx10, nx_idx10;
	logic [31:0] cnt_wide;
	logic [CNT_W-1:0] cnt_sat;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q <= RST_MAX_ATTEMPTS;
			ack_timeout_q  <= RST_ACK_TIMEOUT;
			conf_timeout_q <= RST_CONF_TIMEOUT;
			start_delay_q  <= RST_START_DELAY;
			exit_delay_q   <= RST_EXIT_DELAY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_ATTEMPTS: max_attempts_q <= cfg_data[2:0];
				REG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_data;
				REG_CONF_TIMEOUT: conf_timeout_q <= cfg_data;
				REG_START_DELAY:  start_delay_q  <= cfg_data;
				REG_EXIT_DELAY:   exit_delay_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held event proceeds when the queue can take both of its possible results.
	assign advance  = valid_s1 && (qcnt_q <= QCNT_W'(QDEPTH - 2));
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= operation;
			cnt_s1  <= instruction_count;
			code_s1 <= response_code;
		end
	end

	// Shared terms of the step logic.
	assign expire    = (timer_q <= 10'd1);
	assign timer_dec = expire ? 10'd0 : timer_q - 10'd1;
	assign retry_ok  = (attempt_q < max_attempts_q);
	assign att_inc   = attempt_q + 3'd1;
	assign nx_idx    = (phase_q == PH_WAIT_ENTERED) ? '0 : cur_q + CNT_W'(1);
	assign cur_wide  = {10'd0, cur_q};
	assign nx_wide   = {10'd0, nx_idx};
	assign cur_idx10 = cur_wide[9:0];
	assign nx_idx10  = nx_wide[9:0];
	assign cnt_wide  = {21'd0, cnt_s1};
	assign cnt_sat   = (cnt_wide > MAX_CNT) ? MAX_CNT[CNT_W-1:0] : cnt_wide[CNT_W-1:0];

	// Step logic: next state and the results of the held event.
	always_comb begin
		phase_n   = phase_q;
		attempt_n = attempt_q;
		timer_n   = timer_q;
		cur_n     = cur_q;
		total_n   = total_q;
		nres      = 2'd0;
		res0      = mk_res(ACT_NONE, 10'd0, 4'd0);
		res1      = mk_res(ACT_NONE, 10'd0, 4'd0);
		case (op_s1)
			OP_START: begin
				if (phase_q != PH_IDLE) begin
					res0 = mk_res(ACT_STATUS, 10'd0, ST_BUSY);
					nres = 2'd1;
				end else begin
					total_n   = cnt_sat;
					cur_n     = '0;
					attempt_n = 3'd0;
					phase_n   = PH_START_DELAY;
					timer_n   = start_delay_q;
					if (start_delay_q == 10'd0) begin
						// Zero delay sends APP and enter at once.
						res0      = mk_res(ACT_APP, 10'd0, 4'd0);
						res1      = mk_res(ACT_ENTER, 10'd0, 4'd0);
						nres      = 2'd2;
						attempt_n = 3'd1;
						phase_n   = PH_WAIT_ACK;
						timer_n   = ack_timeout_q;
					end
				end
			end
			OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					timer_n = timer_dec;
				end
				if (expire) begin
					case (phase_q)
						PH_START_DELAY: begin
							res0      = mk_res(ACT_APP, 10'd0, 4'd0);
							res1      = mk_res(ACT_ENTER, 10'd0, 4'd0);
							nres      = 2'd2;
							attempt_n = 3'd1;
							phase_n   = PH_WAIT_ACK;
							timer_n   = ack_timeout_q;
						end
						PH_WAIT_ACK, PH_WAIT_ENTERED: begin
							nres = 2'd1;
							if (retry_ok) begin
								res0      = mk_res(ACT_ENTER, 10'd0, 4'd0);
								attempt_n = att_inc;
								phase_n   = PH_WAIT_ACK;
								timer_n   = ack_timeout_q;
							end else begin
								res0      = mk_res(ACT_STATUS, 10'd0, ST_ENTER_TIMEOUT);
								attempt_n = 3'd0;
								phase_n   = PH_IDLE;
								timer_n   = 10'd0;
							end
						end
						PH_WAIT_REPLY: begin
							if (retry_ok) begin
								res0      = mk_res(ACT_INSTR, cur_idx10, 4'd0);
								nres      = 2'd1;
								attempt_n = att_inc;
								timer_n   = ack_timeout_q;
							end else begin
								res0      = mk_res(ACT_EXIT, 10'd0, 4'd0);
								res1      = mk_res(ACT_STATUS, 10'd0, ST_INSTR_SPENT);
								nres      = 2'd2;
								attempt_n = 3'd0;
								phase_n   = PH_IDLE;
								timer_n   = 10'd0;
							end
						end
						PH_EXIT_DELAY: begin
							res0      = mk_res(ACT_EXIT, 10'd0, 4'd0);
							nres      = 2'd1;
							attempt_n = 3'd1;
							phase_n   = PH_WAIT_EXITED;
							timer_n   = conf_timeout_q;
						end
						PH_WAIT_EXITED: begin
							nres = 2'd1;
							if (retry_ok) begin
								res0      = mk_res(ACT_EXIT, 10'd0, 4'd0);
								attempt_n = att_inc;
								timer_n   = conf_timeout_q;
							end else begin
								res0      = mk_res(ACT_STATUS, 10'd0, ST_EXIT_TIMEOUT);
								attempt_n = 3'd0;
								phase_n   = PH_IDLE;
								timer_n   = 10'd0;
							end
						end
						default: ;
					endcase
				end
			end
			OP_RESPONSE: begin
				case (phase_q)
					PH_WAIT_ACK: begin
						if (code_s1 == RSP_OK) begin
							phase_n = PH_WAIT_ENTERED;
							timer_n = conf_timeout_q;
						end else if (code_s1 >= RSP_MANUAL && code_s1 <= RSP_BAD_SUM) begin
							// A refusal of the enter request ends the job with its code.
							res0      = mk_res(ACT_STATUS, 10'd0, code_s1);
							nres      = 2'd1;
							attempt_n = 3'd0;
							phase_n   = PH_IDLE;
							timer_n   = 10'd0;
						end
					end
					PH_WAIT_ENTERED, PH_WAIT_REPLY: begin
						if ((phase_q == PH_WAIT_ENTERED && code_s1 == RSP_ENTERED) ||
								(phase_q == PH_WAIT_REPLY && (code_s1 == RSP_OK ||
								code_s1 == RSP_DATA || code_s1 == RSP_READY))) begin
							// Move on to the next instruction, or to the exit delay after the last.
							cur_n = nx_idx;
							if (nx_idx >= total_q) begin
								attempt_n = 3'd0;
								phase_n   = PH_EXIT_DELAY;
								timer_n   = exit_delay_q;
								if (exit_delay_q == 10'd0) begin
									res0      = mk_res(ACT_EXIT, 10'd0, 4'd0);
									nres      = 2'd1;
									attempt_n = 3'd1;
									phase_n   = PH_WAIT_EXITED;
									timer_n   = conf_timeout_q;
								end
							end else begin
								res0      = mk_res(ACT_INSTR, nx_idx10, 4'd0);
								nres      = 2'd1;
								attempt_n = 3'd1;
								phase_n   = PH_WAIT_REPLY;
								timer_n   = ack_timeout_q;
							end
						end else if (phase_q == PH_WAIT_REPLY && code_s1 == RSP_BAD_PARAM) begin
							if (retry_ok) begin
								res0      = mk_res(ACT_INSTR, cur_idx10, 4'd0);
								nres      = 2'd1;
								attempt_n = att_inc;
								timer_n   = ack_timeout_q;
							end else begin
								res0      = mk_res(ACT_EXIT, 10'd0, 4'd0);
								res1      = mk_res(ACT_STATUS, 10'd0, ST_INSTR_SPENT);
								nres      = 2'd2;
								attempt_n = 3'd0;
								phase_n   = PH_IDLE;
								timer_n   = 10'd0;
							end
						end else if (phase_q == PH_WAIT_REPLY && code_s1 == RSP_NOT_IN_MODE) begin
							res0      = mk_res(ACT_STATUS, 10'd0, ST_NOT_IN_MODE);
							nres      = 2'd1;
							attempt_n = 3'd0;
							phase_n   = PH_IDLE;
							timer_n   = 10'd0;
						end
					end
					PH_WAIT_EXITED: begin
						if (code_s1 == RSP_EXITED) begin
							res0      = mk_res(ACT_STATUS, 10'd0, ST_SUCCESS);
							nres      = 2'd1;
							attempt_n = 3'd0;
							phase_n   = PH_IDLE;
							timer_n   = 10'd0;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		// Mark the final result of this event.
		if (nres == 2'd1) begin
			res0.last = 1'b1;
		end
		if (nres == 2'd2) begin
			res1.last = 1'b1;
		end
	end

	// Sequencer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			attempt_q <= 3'd0;
			timer_q   <= 10'd0;
			cur_q     <= '0;
			total_q   <= '0;
		end else if (advance) begin
			phase_q   <= phase_n;
			attempt_q <= attempt_n;
			timer_q   <= timer_n;
			cur_q     <= cur_n;
			total_q   <= total_n;
		end
	end

	// Result queue: up to two pushes and one pop per cycle.
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			qcnt_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + QPTR_W'(1);
			end
			qcnt_q <= qcnt_q + (advance ? QCNT_W'(nres) : QCNT_W'(0)) -
				(pop ? QCNT_W'(1) : QCNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (advance && nres != 2'd0) begin
			queue_q[head_q + qcnt_q[QPTR_W-1:0]] <= res0;
		end
		if (advance && nres == 2'd2) begin
			queue_q[head_q + qcnt_q[QPTR_W-1:0] + QPTR_W'(1)] <= res1;
		end
	end

	// Output transaction from the head of the queue.
	assign out_valid         = (qcnt_q != '0);
	assign action            = queue_q[head_q].action;
	assign instruction_index = queue_q[head_q].index;
	assign status            = queue_q[head_q].status;
	assign last              = queue_q[head_q].last;

	// The result queue never holds more entries than it has.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");

	// Every job end leaves the attempt count and timer cleared.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> attempt_q == 3'd0 && timer_q == 10'd0)
		else $error("idle phase with stale attempt count or timer");

	// A status report is always the final result of its event.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_STATUS |-> last)
		else $error("status result not marked last");

	// Only real actions enter the queue.
	a_no_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> action != ACT_NONE)
		else $error("queued result carries no action");

endmodule

@@ bench/firmware_load_retry_sequencer_tb.sv @@
// Self-checking testbench for the firmware load retry sequencer: directed and random events.
`timescale 1ns / 1ps
module firmware_load_retry_sequencer_tb;
	import flrs_pkg::*;

	localparam int MAX_INSTRUCTIONS = 1024;
	localparam logic [10:0] COUNT_CEILING = 11'(MAX_INSTRUCTIONS);
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [3:0] RSP_TOP = 4'd15;

	// Tracks the sequencer state and holds the results that are due, oldest first.
	class fw_load_scoreboard;
		phase_t      ph;
		logic [2:0]  attempts;
		logic [9:0]  timer;
		logic [10:0] cur_idx;
		logic [10:0] total;
		logic [2:0]  max_att;
		logic [9:0]  ack_timeout;
		logic [9:0]  conf_timeout;
		logic [9:0]  start_delay;
		logic [9:0]  exit_delay;
		res_t        due_results[$];
		int          mismatches;
		int          events;
		int          checked;

		function new();
			ph = PH_IDLE;
			attempts = '0;
			timer = '0;
			cur_idx = '0;
			total = '0;
			max_att = RST_MAX_ATTEMPTS;
			ack_timeout = RST_ACK_TIMEOUT;
			conf_timeout = RST_CONF_TIMEOUT;
			start_delay = RST_START_DELAY;
			exit_delay = RST_EXIT_DELAY;
			mismatches = 0;
			events = 0;
			checked = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void write_reg(logic [2:0] idx, logic [9:0] val);
			case (idx)
				REG_MAX_ATTEMPTS: max_att = val[2:0];
				REG_ACK_TIMEOUT:  ack_timeout = val;
				REG_CONF_TIMEOUT: conf_timeout = val;
				REG_START_DELAY:  start_delay = val;
				REG_EXIT_DELAY:   exit_delay = val;
				default: ;
			endcase
		endfunction

		function void push(action_t act, logic [9:0] idx, logic [3:0] st);
			res_t r;
			r.action = act;
			r.index = idx;
			r.status = st;
			r.last = 1'b0;
			due_results.push_back(r);
		endfunction

		// Ends the job with a final status.
		function void conclude(logic [3:0] st);
			ph = PH_IDLE;
			attempts = '0;
			timer = '0;
			push(ACT_STATUS, '0, st);
		endfunction

		// A timer at zero or one runs out on this tick.
		function bit expire();
			if (timer <= 10'd1) begin
				timer = '0;
				return 1'b1;
			end
			timer = timer - 10'd1;
			return 1'b0;
		endfunction

		function void issue_enter();
			attempts = attempts + 3'd1;
			ph = PH_WAIT_ACK;
			timer = ack_timeout;
			push(ACT_ENTER, '0, ST_SUCCESS);
		endfunction

		function void issue_exit();
			attempts = attempts + 3'd1;
			ph = PH_WAIT_EXITED;
			timer = conf_timeout;
			push(ACT_EXIT, '0, ST_SUCCESS);
		endfunction

		function void issue_instr();
			attempts = attempts + 3'd1;
			ph = PH_WAIT_REPLY;
			timer = ack_timeout;
			push(ACT_INSTR, cur_idx[9:0], ST_SUCCESS);
		endfunction

		function void open_exit_delay();
			attempts = '0;
			ph = PH_EXIT_DELAY;
			timer = exit_delay;
			if (timer == '0)
				issue_exit();
		endfunction

		function void advance();
			attempts = '0;
			if (cur_idx >= total)
				open_exit_delay();
			else
				issue_instr();
		endfunction

		function void launch();
			push(ACT_APP, '0, ST_SUCCESS);
			attempts = '0;
			issue_enter();
		endfunction

		function void retry_enter();
			if (attempts < max_att)
				issue_enter();
			else
				conclude(ST_ENTER_TIMEOUT);
		endfunction

		// With no tries left the block still sends exit, then reports.
		function void retry_instr();
			if (attempts < max_att) begin
				issue_instr();
			end else begin
				push(ACT_EXIT, '0, ST_SUCCESS);
				conclude(ST_INSTR_SPENT);
			end
		endfunction

		function void retry_exit();
			if (attempts < max_att)
				issue_exit();
			else
				conclude(ST_EXIT_TIMEOUT);
		endfunction

		// Works out the results of one accepted event transaction.
		function void apply_event(logic [1:0] op, logic [10:0] cnt, logic [3:0] code);
			int count_prior;
			count_prior = due_results.size();
			events++;
			case (op)
				OP_START: begin
					if (ph != PH_IDLE) begin
						push(ACT_STATUS, '0, ST_BUSY);
					end else begin
						total = (cnt > COUNT_CEILING) ? COUNT_CEILING : cnt;
						cur_idx = '0;
						attempts = '0;
						ph = PH_START_DELAY;
						timer = start_delay;
						if (timer == '0)
							launch();
					end
				end
				OP_TICK: begin
					case (ph)
						PH_START_DELAY: if (expire()) launch();
						PH_WAIT_ACK, PH_WAIT_ENTERED: if (expire()) retry_enter();
						PH_WAIT_REPLY: if (expire()) retry_instr();
						PH_EXIT_DELAY: begin
							if (expire()) begin
								attempts = '0;
								issue_exit();
							end
						end
						PH_WAIT_EXITED: if (expire()) retry_exit();
						default: ;
					endcase
				end
				OP_RESPONSE: begin
					case (ph)
						PH_WAIT_ACK: begin
							if (code == RSP_OK) begin
								ph = PH_WAIT_ENTERED;
								timer = conf_timeout;
							end else if (code >= RSP_MANUAL && code <= RSP_BAD_SUM) begin
								conclude(code);
							end
						end
						PH_WAIT_ENTERED: begin
							if (code == RSP_ENTERED) begin
								cur_idx = '0;
								advance();
							end
						end
						PH_WAIT_REPLY: begin
							if (code == RSP_OK || code == RSP_DATA || code == RSP_READY) begin
								cur_idx = cur_idx + 11'd1;
								advance();
							end else if (code == RSP_BAD_PARAM) begin
								retry_instr();
							end else if (code == RSP_NOT_IN_MODE) begin
								conclude(ST_NOT_IN_MODE);
							end
						end
						PH_WAIT_EXITED: if (code == RSP_EXITED) conclude(ST_SUCCESS);
						default: ;
					endcase
				end
				default: ;
			endcase
			if (due_results.size() > count_prior)
				due_results[due_results.size() - 1].last = 1'b1;
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 20)
				$display("mismatch at %0t ns: %s", $time, msg);
		endtask

		// Compares one result transaction with the oldest one due.
		task check_result(logic [2:0] act, logic [9:0] idx, logic [3:0] st, logic lst);
			res_t want;
			if (due_results.size() == 0) begin
				report($sformatf("result with action %0d arrived with nothing due", act));
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (act !== want.action)
				report($sformatf("action %0d, wanted %0d", act, want.action));
			if (idx !== want.index)
				report($sformatf("instruction_index %0d, wanted %0d", idx, want.index));
			if (st !== want.status)
				report($sformatf("status %0d, wanted %0d", st, want.status));
			if (lst !== want.last)
				report($sformatf("last %0b, wanted %0b", lst, want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_TICK;
	logic [10:0] instruction_count = '0;
	logic [3:0]  response_code = RSP_OK;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  action;
	logic [9:0]  instruction_index;
	logic [3:0]  status;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_MAX_ATTEMPTS;
	logic [9:0]  cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	fw_load_scoreboard sb;

	firmware_load_retry_sequencer #(
		.MAX_INSTRUCTIONS(MAX_INSTRUCTIONS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.instruction_count(instruction_count),
		.response_code(response_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.instruction_index(instruction_index),
		.status(status),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver stalls are drawn fresh at every falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Both channels are sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.apply_event(operation, instruction_count, response_code);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(action, instruction_index, status, last);
	end

	// Drives one event transaction from a falling edge until it is taken.
	task automatic send_event(input logic [1:0] op, input logic [10:0] cnt,
			input logic [3:0] code);
		in_valid = 1'b1;
		operation = op;
		instruction_count = cnt;
		response_code = code;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Holds the sender off until every due result has come and the pipeline is empty.
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_setting(input logic [2:0] att, input logic [9:0] ack,
			input logic [9:0] conf, input logic [9:0] sdel, input logic [9:0] edel,
			input int spct, input int rpct);
		settle();
		write_reg(REG_MAX_ATTEMPTS, {7'd0, att});
		write_reg(REG_ACK_TIMEOUT, ack);
		write_reg(REG_CONF_TIMEOUT, conf);
		write_reg(REG_START_DELAY, sdel);
		write_reg(REG_EXIT_DELAY, edel);
		send_idle_pct = spct;
		recv_stall_pct = rpct;
	endtask

	// Picks the next event from the current phase, mostly what that phase waits for.
	task automatic pick_event(output logic [1:0] op, output logic [10:0] cnt,
			output logic [3:0] code, output bit counted);
		int r;
		int sel;
		r = $urandom_range(99);
		op = OP_RESPONSE;
		cnt = 11'($urandom_range(2047));
		code = 4'($urandom_range(15));
		counted = 1'b1;
		case (sb.ph)
			PH_IDLE: begin
				if (r < 90) begin
					op = OP_START;
					sel = $urandom_range(99);
					if (sel < 85)
						cnt = 11'($urandom_range(3));
					else if (sel < 95)
						cnt = 11'($urandom_range(12, 4));
				end else begin
					r = 100;
				end
			end
			PH_START_DELAY, PH_EXIT_DELAY: begin
				if (r < 95) op = OP_TICK;
				else r = 100;
			end
			PH_WAIT_ACK: begin
				if (r < 65) code = RSP_OK;
				else if (r < 72) code = 4'($urandom_range(RSP_BAD_SUM, RSP_MANUAL));
				else if (r < 88) op = OP_TICK;
				else r = 100;
			end
			PH_WAIT_ENTERED: begin
				if (r < 70) code = RSP_ENTERED;
				else if (r < 88) op = OP_TICK;
				else r = 100;
			end
			PH_WAIT_REPLY: begin
				// Long jobs are cut short now and then so that the run sees many jobs.
				if (sb.total > 11'd16 && $urandom_range(15) == 0) begin
					code = RSP_NOT_IN_MODE;
				end else if (r < 62) begin
					sel = $urandom_range(2);
					code = (sel == 0) ? RSP_OK : (sel == 1) ? RSP_DATA : RSP_READY;
				end else if (r < 72) begin
					code = RSP_BAD_PARAM;
				end else if (r < 74) begin
					code = RSP_NOT_IN_MODE;
				end else if (r < 90) begin
					op = OP_TICK;
				end else begin
					r = 100;
				end
			end
			PH_WAIT_EXITED: begin
				if (r < 70) code = RSP_EXITED;
				else if (r < 88) op = OP_TICK;
				else r = 100;
			end
			default: r = 100;
		endcase
		// Noise: unused operations, stray ticks, random responses and starts.
		if (r == 100) begin
			counted = 1'b0;
			sel = $urandom_range(3);
			op = (sel == 0) ? OP_UNUSED : (sel == 1) ? OP_TICK :
				(sel == 2) ? OP_RESPONSE : OP_START;
		end
	endtask

	task automatic run_random(input int n);
		int done_n;
		logic [1:0] op;
		logic [10:0] cnt;
		logic [3:0] code;
		bit counted;
		done_n = 0;
		while (done_n < n) begin
			pick_event(op, cnt, code, counted);
			send_event(op, cnt, code);
			if (counted)
				done_n++;
		end
	endtask

	// Main sequence: reset, directed events, then random events over several settings.
	initial begin
		int guard;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Register values from reset: saturated count, busy start, start delay of five.
		send_event(OP_START, 11'd2047, RSP_TOP);
		send_event(OP_START, 11'd0, RSP_OK);
		repeat (5) send_event(OP_TICK, 11'd0, RSP_OK);
		send_event(OP_RESPONSE, 11'd0, 4'd11);
		send_event(OP_RESPONSE, 11'd0, RSP_OK);
		send_event(OP_RESPONSE, 11'd0, RSP_ENTERED);
		send_event(OP_RESPONSE, 11'd0, RSP_DATA);
		send_event(OP_RESPONSE, 11'd0, RSP_READY);
		send_event(OP_RESPONSE, 11'd0, RSP_BAD_PARAM);
		send_event(OP_RESPONSE, 11'd0, RSP_TOP);
		send_event(OP_UNUSED, 11'd2047, RSP_TOP);
		send_event(OP_RESPONSE, 11'd0, RSP_NOT_IN_MODE);

		// Single tries with zero delays: refusal, instruction retries spent, exit timeout.
		apply_setting(3'd1, 10'd1, 10'd1, 10'd0, 10'd0, 85, 0);
		send_event(OP_START, 11'd0, RSP_OK);
		send_event(OP_RESPONSE, 11'd0, RSP_BAD_SUM);
		send_event(OP_START, 11'd1, RSP_OK);
		send_event(OP_RESPONSE, 11'd0, RSP_OK);
		send_event(OP_RESPONSE, 11'd0, RSP_ENTERED);
		send_event(OP_TICK, 11'd0, RSP_OK);
		send_event(OP_START, 11'd0, RSP_OK);
		send_event(OP_RESPONSE, 11'd0, RSP_OK);
		send_event(OP_RESPONSE, 11'd0, RSP_ENTERED);
		send_event(OP_TICK, 11'd0, RSP_OK);
		run_random(175);

		apply_setting(3'd3, 10'd3, 10'd4, 10'd2, 10'd2, 0, 0);
		run_random(175);
		apply_setting(3'd7, 10'd2, 10'd3, 10'd1, 10'd1, 0, 85);
		run_random(175);
		// Zero attempts and zero timeouts behave as one.
		apply_setting(3'd0, 10'd0, 10'd0, 10'd3, 10'd0, 8, 8);
		run_random(175);
		apply_setting(3'd7, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 8, 8);
		run_random(1200);

		// Drain what is still due, with a bound, and let the pipeline empty.
		in_valid = 1'b0;
		guard = 0;
		while (sb.pending() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));

		$display("Ran %0d event transactions and checked %0d result transactions", sb.events,
			sb.checked);
		$display("over six register settings, with sender gaps and receiver stalls.");
		if (sb.mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Hard limit on the run time.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
